// ----- rtl/apdd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axle pulse direction detector package
// Shared types, register indexes and reset values for the detector blocks.
// ----------------------------------------------------------------------------
package apdd_pkg;

  localparam int TimerBitsDef = 16;
  localparam int TallyBitsDef = 16;

  localparam int CfgIdxW = 2;
  localparam int ThrW    = 4;

  localparam logic [ThrW-1:0] DirThrRst    = 4'd4;
  localparam logic [ThrW-1:0] AxleThrRst   = 4'd2;
  localparam logic [ThrW-1:0] SingleThrRst = 4'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DETECT_MODE = 2'd0,
    CFG_DIR_THR     = 2'd1,
    CFG_AXLE_THR    = 2'd2,
    CFG_SINGLE_THR  = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SENSOR_NONE = 2'd0,
    SENSOR_A    = 2'd1,
    SENSOR_B    = 2'd2
  } sensor_e;

  typedef enum logic [1:0] {
    DIR_UNKNOWN  = 2'd0,
    DIR_TOWARD_A = 2'd1,
    DIR_TOWARD_B = 2'd2
  } dir_e;

  typedef struct packed {
    logic            detect_mode;
    logic [ThrW-1:0] dir_thr;
    logic [ThrW-1:0] axle_thr;
    logic [ThrW-1:0] single_thr;
  } cfg_t;

  typedef struct packed {
    logic single_axle;
    logic axle_found;
    logic dir_found;
  } flags_t;

endpackage

// ----- rtl/apdd_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axle pulse direction detector configuration registers
// Holds the mode and the three count thresholds written over the cfg channel.
// ----------------------------------------------------------------------------
module apdd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [apdd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [apdd_pkg::ThrW-1:0]    cfg_data_i,
  output apdd_pkg::cfg_t               cfg_o
);

  apdd_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detect_mode <= 1'b0;
      cfg_q.dir_thr     <= apdd_pkg::DirThrRst;
      cfg_q.axle_thr    <= apdd_pkg::AxleThrRst;
      cfg_q.single_thr  <= apdd_pkg::SingleThrRst;
    end else if (cfg_valid_i) begin
      case (apdd_pkg::cfg_reg_e'(cfg_index_i))
        apdd_pkg::CFG_DETECT_MODE: cfg_q.detect_mode <= cfg_data_i[0];
        apdd_pkg::CFG_DIR_THR:     cfg_q.dir_thr     <= cfg_data_i;
        apdd_pkg::CFG_AXLE_THR:    cfg_q.axle_thr    <= cfg_data_i;
        apdd_pkg::CFG_SINGLE_THR:  cfg_q.single_thr  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/apdd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axle pulse direction detector core
// Detector state and the combinational update for one registered pulse.
// ----------------------------------------------------------------------------
module apdd_core #(
  parameter int TIMER_BITS = apdd_pkg::TimerBitsDef,
  parameter int TALLY_BITS = apdd_pkg::TallyBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  sensor_i,
  input  logic [TIMER_BITS-1:0] ticks_i,
  input  logic                  ovf_i,
  input  apdd_pkg::cfg_t        cfg_i,
  output apdd_pkg::dir_e        dir_o,
  output logic [TIMER_BITS-1:0] interval_o,
  output apdd_pkg::flags_t      flags_o,
  output logic [TALLY_BITS-1:0] axle_total_o,
  output logic [TALLY_BITS-1:0] missed_a_o,
  output logic [TALLY_BITS-1:0] missed_b_o
);

  apdd_pkg::sensor_e          last_q, last_d;
  logic [TIMER_BITS-1:0]      ab_q, ab_d, ba_q, ba_d, chosen_q, chosen_d;
  logic [apdd_pkg::ThrW-1:0]  cnt_q, cnt_d;
  apdd_pkg::dir_e             dir_q, dir_d;
  apdd_pkg::flags_t           flags_q, flags_d;
  logic [TALLY_BITS-1:0]      axle_q, axle_d, missa_q, missa_d, missb_q, missb_d;

  apdd_pkg::sensor_e          which;
  logic                       take, miss;
  logic [TIMER_BITS-1:0]      span;
  logic [apdd_pkg::ThrW-1:0]  cnt;

  always_comb begin
    last_d   = last_q;
    ab_d     = ab_q;
    ba_d     = ba_q;
    chosen_d = chosen_q;
    cnt_d    = cnt_q;
    dir_d    = dir_q;
    flags_d  = flags_q;
    axle_d   = axle_q;
    missa_d  = missa_q;
    missb_d  = missb_q;
    which    = sensor_i ? apdd_pkg::SENSOR_B : apdd_pkg::SENSOR_A;
    // Frequency mode ignores sensor B altogether
    take     = !cfg_i.detect_mode || !sensor_i;
    miss     = cfg_i.detect_mode ? (last_q == apdd_pkg::SENSOR_B) : (last_q == which);
    span     = '0;
    cnt      = cnt_q;
    if (take) begin
      if (miss) begin
        cnt = '0;
        if (which == apdd_pkg::SENSOR_A) missa_d = missa_q + 1'b1;
        else                             missb_d = missb_q + 1'b1;
      end
      if (last_q != apdd_pkg::SENSOR_NONE) span = ovf_i ? '1 : ticks_i;
      last_d = which;
      if (which == apdd_pkg::SENSOR_A) ba_d = span;
      else                             ab_d = span;
      cnt = cnt + 1'b1;
      if (cnt >= cfg_i.dir_thr) begin
        if (ab_d < ba_d) begin
          dir_d    = apdd_pkg::DIR_TOWARD_A;
          chosen_d = ab_d;
        end else if (ba_d < ab_d) begin
          dir_d    = apdd_pkg::DIR_TOWARD_B;
          chosen_d = ba_d;
        end else begin
          chosen_d = '1;
        end
        flags_d.dir_found = 1'b1;
        cnt = apdd_pkg::ThrW'(1);
      end else if (cnt >= cfg_i.axle_thr) begin
        chosen_d           = (ab_d != '0) ? ab_d : ba_d;
        axle_d             = axle_q + 1'b1;
        flags_d.axle_found = 1'b1;
      end else if (cfg_i.detect_mode && (cnt >= cfg_i.single_thr)) begin
        chosen_d            = ba_d;
        axle_d              = axle_q + 1'b1;
        flags_d.single_axle = 1'b1;
        cnt = '0;
      end
      cnt_d = cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= apdd_pkg::SENSOR_NONE;
      ab_q     <= '0;
      ba_q     <= '0;
      chosen_q <= '0;
      cnt_q    <= '0;
      dir_q    <= apdd_pkg::DIR_UNKNOWN;
      flags_q  <= '0;
      axle_q   <= '0;
      missa_q  <= '0;
      missb_q  <= '0;
    end else if (step_i) begin
      last_q   <= last_d;
      ab_q     <= ab_d;
      ba_q     <= ba_d;
      chosen_q <= chosen_d;
      cnt_q    <= cnt_d;
      dir_q    <= dir_d;
      flags_q  <= flags_d;
      axle_q   <= axle_d;
      missa_q  <= missa_d;
      missb_q  <= missb_d;
    end
  end

  // Results reflect the state after this pulse
  assign dir_o        = dir_d;
  assign interval_o   = chosen_d;
  assign flags_o      = flags_d;
  assign axle_total_o = axle_d;
  assign missed_a_o   = missa_d;
  assign missed_b_o   = missb_d;

endmodule

// ----- rtl/axle_pulse_direction_detector_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axle pulse direction detector top level
// Turns A/B magnet sensor pulses into direction, interval, flags and tallies.
// ----------------------------------------------------------------------------
// Input stream: one transaction per sensor pulse. tuser carries the sensor
// (0 A, 1 B); tdata carries elapsed ticks and the timer overflow bit.
// Output stream: one transaction per pulse with direction, chosen interval,
// the three sticky flags and the axle and miss tallies.
// Config channel: cfg_index_i selects mode (0), direction threshold (1),
// axle threshold (2) or single-axle threshold (3); write only while idle.
// A pulse accepted into the input register has its state update written into
// the output register when it advances, and the result is then offered on
// the output stream. A pulse can be accepted every cycle while the receiver
// keeps up; the detector state update between those two registers is
// combinational.
// When the receiver stalls, the output register holds its transaction and
// the input register takes one more pulse before tready drops.
// Reset clears all detector state, flags and tallies and loads the default
// thresholds (direction 4, axle 2, single 1) in paired mode.
// ----------------------------------------------------------------------------
module axle_pulse_direction_detector_top #(
  parameter int TIMER_BITS = apdd_pkg::TimerBitsDef,
  parameter int TALLY_BITS = apdd_pkg::TallyBitsDef,
  localparam int InW       = TIMER_BITS + 1,
  localparam int InTdataW  = ((InW + 7) / 8) * 8,
  localparam int OutW      = 2 + TIMER_BITS + 3 + 3 * TALLY_BITS,
  localparam int OutTdataW = ((OutW + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // elapsed_ticks, overflowed
  input  logic [InTdataW-1:0]          s_axis_tdata_i,
  // sensor
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // direction, interval, flag_direction_found, flag_axle_found,
  // flag_single_axle, axle_total, missed_a_total, missed_b_total
  output logic [OutTdataW-1:0]         m_axis_tdata_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [apdd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [apdd_pkg::ThrW-1:0]    cfg_data_i
);

  apdd_pkg::cfg_t        cfg;
  logic                  in_valid_q, out_valid_q, adv;
  logic [InW-1:0]        in_data_q;
  logic                  in_sensor_q;
  logic [OutW-1:0]       out_data_q, out_data_d;
  apdd_pkg::flags_t      held_flags;

  apdd_pkg::dir_e        res_dir;
  logic [TIMER_BITS-1:0] res_interval;
  apdd_pkg::flags_t      res_flags;
  logic [TALLY_BITS-1:0] res_axle, res_missa, res_missb;

  apdd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance the held pulse when the output register is free or draining
  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_data_q   <= s_axis_tdata_i[InW-1:0];
      in_sensor_q <= s_axis_tuser_i;
    end
  end

  apdd_core #(
    .TIMER_BITS (TIMER_BITS),
    .TALLY_BITS (TALLY_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (adv),
    .sensor_i     (in_sensor_q),
    .ticks_i      (in_data_q[TIMER_BITS-1:0]),
    .ovf_i        (in_data_q[TIMER_BITS]),
    .cfg_i        (cfg),
    .dir_o        (res_dir),
    .interval_o   (res_interval),
    .flags_o      (res_flags),
    .axle_total_o (res_axle),
    .missed_a_o   (res_missa),
    .missed_b_o   (res_missb)
  );

  assign out_data_d = {res_missb, res_missa, res_axle, res_flags, res_interval, res_dir};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_data_q <= '0;
    end else if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutTdataW'(out_data_q);

  assign held_flags = out_data_q[TIMER_BITS+4:TIMER_BITS+2];

  // Input stall only happens with both registers full and the receiver stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a full pipeline");

  // Every advanced pulse shows up in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("advanced pulse produced no result");

  // Detection flags are sticky until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(held_flags.dir_found) && !$fell(held_flags.axle_found) &&
    !$fell(held_flags.single_axle))
    else $error("sticky flag cleared");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axle pulse direction detector testbench
// Streams A/B sensor pulses into the detector under a series of mode and
// threshold settings. Random idling, stalls and one long receiver hold-off
// are applied. Every output transaction is checked field by field against
// a cycle-free model of the detector state kept alongside.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic        is_b;
    logic [15:0] ticks;
    logic        ovf;
  } pulse_t;

  // Lowest field in the lowest bits, as on m_axis_tdata_o
  typedef struct packed {
    logic [2:0]     pad;
    logic [15:0]    missed_b;
    logic [15:0]    missed_a;
    logic [15:0]    axle_total;
    logic           single_axle;
    logic           axle_found;
    logic           dir_found;
    logic [15:0]    interval;
    apdd_pkg::dir_e direction;
  } detector_out_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // elapsed_ticks, overflowed
  logic [23:0] s_axis_tdata_i  = '0;
  // sensor
  logic        s_axis_tuser_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // direction, interval, flag_direction_found, flag_axle_found,
  // flag_single_axle, axle_total, missed_a_total, missed_b_total
  logic [71:0] m_axis_tdata_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i     = apdd_pkg::CFG_DETECT_MODE;
  logic [3:0]  cfg_data_i      = '0;

  // Detector state as the model sees it
  apdd_pkg::cfg_t    cfg_shadow = '{detect_mode: 1'b0, dir_thr: apdd_pkg::DirThrRst,
                                    axle_thr: apdd_pkg::AxleThrRst,
                                    single_thr: apdd_pkg::SingleThrRst};
  apdd_pkg::sensor_e last_seen  = apdd_pkg::SENSOR_NONE;
  logic [15:0]       span_ab    = '0;
  logic [15:0]       span_ba    = '0;
  logic [3:0]        pulses     = '0;
  logic [15:0]       chosen     = '0;
  apdd_pkg::dir_e    heading    = apdd_pkg::DIR_UNKNOWN;
  apdd_pkg::flags_t  found      = '0;
  logic [15:0]       axles      = '0;
  logic [15:0]       miss_a     = '0;
  logic [15:0]       miss_b     = '0;

  pulse_t        pulses_to_send[$];
  detector_out_t reports_due[$];

  int   mismatch_cnt  = 0;
  int   tx_idle       = 0;
  int   rx_idle       = 0;
  int   rx_hold       = 0;
  logic in_fire       = 1'b0;
  logic quiet         = 1'b0;
  logic rx_long_req   = 1'b0;
  logic rx_long_done  = 1'b0;
  logic prev_b        = 1'b0;

  axle_pulse_direction_detector_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one pulse to the detector state and return the report it yields
  task automatic advance_detector(input logic is_b, input logic [15:0] ticks,
                                  input logic ovf, output detector_out_t rep);
    apdd_pkg::sensor_e hit;
    logic              freq;
    logic [15:0]       span;
    hit  = is_b ? apdd_pkg::SENSOR_B : apdd_pkg::SENSOR_A;
    freq = cfg_shadow.detect_mode;
    if (!freq || hit == apdd_pkg::SENSOR_A) begin
      if (!freq && hit == last_seen) begin
        pulses = '0;
        if (hit == apdd_pkg::SENSOR_A) miss_a = miss_a + 16'd1;
        else miss_b = miss_b + 16'd1;
      end else if (freq && last_seen == apdd_pkg::SENSOR_B) begin
        pulses = '0;
        miss_a = miss_a + 16'd1;
      end
      span = (last_seen == apdd_pkg::SENSOR_NONE) ? 16'd0 : (ovf ? 16'hFFFF : ticks);
      last_seen = hit;
      if (hit == apdd_pkg::SENSOR_A) span_ba = span;
      else span_ab = span;
      pulses = pulses + 4'd1;
      if (pulses >= cfg_shadow.dir_thr) begin
        if (span_ab < span_ba) begin
          heading = apdd_pkg::DIR_TOWARD_A;
          chosen  = span_ab;
        end else if (span_ba < span_ab) begin
          heading = apdd_pkg::DIR_TOWARD_B;
          chosen  = span_ba;
        end else begin
          // equal intervals: keep the direction, saturate the interval
          chosen = 16'hFFFF;
        end
        found.dir_found = 1'b1;
        pulses = 4'd1;
      end else if (pulses >= cfg_shadow.axle_thr) begin
        chosen = (span_ab != 16'd0) ? span_ab : span_ba;
        axles  = axles + 16'd1;
        found.axle_found = 1'b1;
      end else if (freq && pulses >= cfg_shadow.single_thr) begin
        chosen = span_ba;
        axles  = axles + 16'd1;
        found.single_axle = 1'b1;
        pulses = '0;
      end
    end
    rep.pad         = '0;
    rep.direction   = heading;
    rep.interval    = chosen;
    rep.dir_found   = found.dir_found;
    rep.axle_found  = found.axle_found;
    rep.single_axle = found.single_axle;
    rep.axle_total  = axles;
    rep.missed_a    = miss_a;
    rep.missed_b    = miss_b;
  endtask

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Check the output transaction first, then predict the accepted pulse
  always @(posedge clk_i) begin : scoreboard
    detector_out_t got;
    detector_out_t want;
    in_fire = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = detector_out_t'(m_axis_tdata_o);
        if (reports_due.size() == 0) begin
          note_mismatch("unexpected transaction, interval", 16'd0, got.interval);
        end else begin
          want = reports_due.pop_front();
          if (got.direction !== want.direction)
            note_mismatch("direction", want.direction, got.direction);
          if (got.interval !== want.interval)
            note_mismatch("interval", want.interval, got.interval);
          if (got.dir_found !== want.dir_found)
            note_mismatch("flag_direction_found", want.dir_found, got.dir_found);
          if (got.axle_found !== want.axle_found)
            note_mismatch("flag_axle_found", want.axle_found, got.axle_found);
          if (got.single_axle !== want.single_axle)
            note_mismatch("flag_single_axle", want.single_axle, got.single_axle);
          if (got.axle_total !== want.axle_total)
            note_mismatch("axle_total", want.axle_total, got.axle_total);
          if (got.missed_a !== want.missed_a)
            note_mismatch("missed_a_total", want.missed_a, got.missed_a);
          if (got.missed_b !== want.missed_b)
            note_mismatch("missed_b_total", want.missed_b, got.missed_b);
          if (got.pad !== want.pad)
            note_mismatch("tdata padding", want.pad, got.pad);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_fire = 1'b1;
        advance_detector(s_axis_tuser_i, s_axis_tdata_i[15:0], s_axis_tdata_i[16], want);
        reports_due.push_back(want);
      end
    end
  end

  always @(negedge clk_i) begin : pulse_driver
    pulse_t nxt;
    if (s_axis_tvalid_i && !in_fire) begin
      // hold the offered transaction
    end else if (tx_idle > 0) begin
      tx_idle--;
      s_axis_tvalid_i <= 1'b0;
    end else if (pulses_to_send.size() != 0 && !quiet && $urandom_range(0, 11) == 0) begin
      tx_idle = $urandom_range(1, 15) - 1;
      s_axis_tvalid_i <= 1'b0;
    end else if (pulses_to_send.size() != 0) begin
      nxt = pulses_to_send.pop_front();
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= {7'd0, nxt.ovf, nxt.ticks};
      s_axis_tuser_i  <= nxt.is_b;
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin : report_sink
    logic go;
    go = 1'b0;
    if (rx_hold > 0) begin
      rx_hold--;
    end else if (rx_long_req && !rx_long_done) begin
      // long hold-off so the block fills and stalls its input
      rx_hold = 79;
      rx_long_done = 1'b1;
    end else if (rx_idle > 0) begin
      rx_idle--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      rx_idle = $urandom_range(1, 15) - 1;
    end else begin
      go = 1'b1;
    end
    m_axis_tready_i <= go;
  end

  task automatic queue_pulse(input logic is_b, input logic [15:0] ticks, input logic ovf);
    pulses_to_send.push_back('{is_b: is_b, ticks: ticks, ovf: ovf});
    prev_b = is_b;
  endtask

  // Mostly well-formed A/B alternation (or mostly A in frequency mode)
  task automatic queue_random(input int n);
    logic        is_b;
    logic [15:0] ticks;
    for (int i = 0; i < n; i++) begin
      if (cfg_shadow.detect_mode)
        is_b = ($urandom_range(0, 99) < 15);
      else
        is_b = ($urandom_range(0, 99) < 85) ? !prev_b : prev_b;
      case ($urandom_range(0, 7))
        0:       ticks = 16'h0000;
        1:       ticks = 16'hFFFF;
        2, 3:    ticks = 16'($urandom_range(0, 255));
        default: ticks = 16'($urandom);
      endcase
      queue_pulse(is_b, ticks, $urandom_range(0, 9) == 0);
    end
  endtask

  // Wait until every pulse is in and every report is out, then drain
  task automatic settle();
    while (pulses_to_send.size() != 0 || s_axis_tvalid_i || reports_due.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input apdd_pkg::cfg_reg_e idx, input logic [3:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      apdd_pkg::CFG_DETECT_MODE: cfg_shadow.detect_mode = val[0];
      apdd_pkg::CFG_DIR_THR:     cfg_shadow.dir_thr     = val;
      apdd_pkg::CFG_AXLE_THR:    cfg_shadow.axle_thr    = val;
      apdd_pkg::CFG_SINGLE_THR:  cfg_shadow.single_thr  = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic mode, input logic [3:0] dthr, input logic [3:0] athr,
                           input logic [3:0] sthr);
    settle();
    write_reg(apdd_pkg::CFG_DETECT_MODE, {3'd0, mode});
    write_reg(apdd_pkg::CFG_DIR_THR, dthr);
    write_reg(apdd_pkg::CFG_AXLE_THR, athr);
    write_reg(apdd_pkg::CFG_SINGLE_THR, sthr);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // paired mode at reset thresholds; first pulse records zero
    queue_pulse(1'b0, 16'h1234, 1'b0);
    queue_pulse(1'b1, 16'h0010, 1'b0);
    queue_pulse(1'b0, 16'h0020, 1'b0);
    queue_pulse(1'b1, 16'hFFFF, 1'b0);
    queue_pulse(1'b0, 16'h0000, 1'b1);
    queue_pulse(1'b0, 16'h0005, 1'b0);
    queue_pulse(1'b1, 16'h0005, 1'b0);
    queue_pulse(1'b0, 16'h0005, 1'b0);
    queue_pulse(1'b1, 16'h0009, 1'b0);
    queue_pulse(1'b1, 16'h0007, 1'b0);
    queue_pulse(1'b0, 16'h8000, 1'b0);
    queue_pulse(1'b1, 16'h7FFF, 1'b1);

    // frequency mode: A after B is a miss, B is ignored, repeated A is normal
    configure(1'b1, 4'd4, 4'd2, 4'd1);
    queue_pulse(1'b0, 16'h0100, 1'b0);
    queue_pulse(1'b0, 16'h0200, 1'b0);
    queue_pulse(1'b1, 16'h0300, 1'b0);
    queue_pulse(1'b0, 16'hFFFF, 1'b0);
    queue_pulse(1'b0, 16'h4321, 1'b1);
    queue_pulse(1'b0, 16'h0001, 1'b0);

    // zero thresholds are always met
    configure(1'b0, 4'd0, 4'd0, 4'd0);
    queue_pulse(1'b1, 16'h00AA, 1'b0);
    queue_pulse(1'b0, 16'h0055, 1'b0);
    queue_pulse(1'b0, 16'h0033, 1'b0);

    configure(1'b0, 4'd4, 4'd2, 4'd1);
    rx_long_req = 1'b1;
    queue_random(150);
    configure(1'b1, 4'd4, 4'd2, 4'd1);
    queue_random(120);
    configure(1'b0, 4'd15, 4'd15, 4'd15);
    queue_random(130);
    configure(1'b0, 4'd1, 4'd1, 4'd1);
    queue_random(120);
    configure(1'b1, 4'd15, 4'd15, 4'd1);
    queue_random(120);
    configure(1'b1, 4'd8, 4'd3, 4'd15);
    queue_random(120);
    configure(1'b0, 4'd0, 4'd0, 4'd0);
    queue_random(60);
    configure(1'b1, 4'd0, 4'd0, 4'd0);
    queue_random(40);
    repeat (2) begin
      configure(1'($urandom_range(0, 1)), 4'($urandom_range(1, 15)),
                4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
      queue_random(120);
    end
    configure(1'b0, 4'd6, 4'd3, 4'd2);
    quiet = 1'b1;
    queue_random(200);

    settle();
    if (mismatch_cnt == 0 && reports_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/apdd_pkg.sv
rtl/apdd_cfg_regs.sv
rtl/apdd_core.sv
rtl/axle_pulse_direction_detector_top.sv
tb/sv/tb.sv
